// ===== rtl/core/meu_pkg.sv =====
// shared constants and codes for the modular exponentiation unit
`default_nettype none

package meu_pkg;

    // operand and product widths
    localparam int OPD_W  = 31;
    localparam int PROD_W = 2 * OPD_W;

    // default exponent width
    localparam int EXP_BITS_DEF = 63;

    // configuration port
    localparam int ADDR_W = 2;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-1:0] ADDR_MODULUS = 2'd0;

    // modulus after reset
    localparam logic [OPD_W-1:0] MODULUS_RESET = 31'd1000000007;

    // request kinds
    localparam logic [1:0] KIND_POW = 2'd0;
    localparam logic [1:0] KIND_INV = 2'd1;
    localparam logic [1:0] KIND_DIV = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/meu_modmul.sv =====
// modular multiplier: one product, then radix-4 serial reduction
`default_nettype none

module meu_modmul
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [meu_pkg::OPD_W-1:0]   x,
    input  wire logic [meu_pkg::OPD_W-1:0]   y,
    input  wire logic [meu_pkg::OPD_W-1:0]   m,
    output logic                             done,
    output logic [meu_pkg::OPD_W-1:0]        r
);

    localparam int STEPS = meu_pkg::PROD_W / 2;
    localparam int CNT_W = $clog2(STEPS);
    localparam int T_W   = meu_pkg::OPD_W + 2;

    logic                          run_reg, run_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [meu_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic [meu_pkg::OPD_W-1:0]     rem_reg, rem_next;
    logic [meu_pkg::OPD_W-1:0]     m1_reg, m1_next;
    logic [meu_pkg::OPD_W:0]       m2_reg, m2_next;
    logic [T_W-1:0]                m3_reg, m3_next;

    logic [meu_pkg::PROD_W-1:0]    prod_w;
    logic [T_W-1:0]                t;
    logic [T_W-1:0]                t_red;

    // single product of the operands
    assign prod_w = x * y;

    // next two product bits shifted into the remainder, minus 0..3 times m
    assign t = {rem_reg, prod_reg[meu_pkg::PROD_W-1 -: 2]};

    always_comb
    begin
        if (t >= m3_reg)
        begin
            t_red = t - m3_reg;
        end
        else if (t >= T_W'(m2_reg))
        begin
            t_red = t - T_W'(m2_reg);
        end
        else if (t >= T_W'(m1_reg))
        begin
            t_red = t - T_W'(m1_reg);
        end
        else
        begin
            t_red = t;
        end
    end

    // sequencing of the reduction steps
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        m1_next   = m1_reg;
        m2_next   = m2_reg;
        m3_next   = m3_reg;
        if (start)
        begin
            run_next  = 1'b1;
            cnt_next  = '0;
            prod_next = prod_w;
            rem_next  = '0;
            m1_next   = m;
            m2_next   = {m, 1'b0};
            m3_next   = T_W'(m) + T_W'({m, 1'b0});
        end
        else if (run_reg)
        begin
            rem_next  = t_red[meu_pkg::OPD_W-1:0];
            prod_next = {prod_reg[meu_pkg::PROD_W-3:0], 2'b00};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        m1_reg   <= m1_next;
        m2_reg   <= m2_next;
        m3_reg   <= m3_next;
    end

    assign done = done_reg;
    assign r    = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/core/modular_exponentiation_unit_core.sv =====
// modular exponentiation unit: power, fermat inverse and division mod a prime
// each modular product runs through the shared multiplier (one multiply, 31
// radix-4 reduction steps, one update); a power with an n-bit exponent of
// weight w takes n-1+w modular products.
// one item at a time: busy stays high until the done strobe; results cannot stall
// reset: sequencer idle, modulus register back to 1000000007
`default_nettype none

module modular_exponentiation_unit_core
#(
    parameter int EXP_BITS = meu_pkg::EXP_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [meu_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [meu_pkg::DATA_W-1:0]   pwdata,
    output logic [meu_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   kind,
    input  wire logic [meu_pkg::OPD_W-1:0]    base,
    input  wire logic [EXP_BITS-1:0]          exponent,
    input  wire logic [meu_pkg::OPD_W-1:0]    divisor,
    output logic                              done,
    output logic [meu_pkg::OPD_W-1:0]         value
);

    localparam int E_W = (EXP_BITS > meu_pkg::OPD_W) ? EXP_BITS : meu_pkg::OPD_W;

    typedef enum logic [2:0]
    {
        S_IDLE = 3'b001,
        S_BIT  = 3'b010,
        S_WAIT = 3'b100
    } state_t;

    typedef enum logic [1:0]
    {
        OP_ACC,
        OP_SQR,
        OP_FIN
    } op_t;

    state_t                        state_reg, state_next;
    op_t                           op_reg, op_next;
    logic                          done_reg, done_next;
    logic [meu_pkg::OPD_W-1:0]     value_reg, value_next;
    logic [meu_pkg::OPD_W-1:0]     modulus_reg;
    logic [1:0]                    kind_reg, kind_next;
    logic [meu_pkg::OPD_W-1:0]     base_reg, base_next;
    logic [meu_pkg::OPD_W-1:0]     a_reg, a_next;
    logic [meu_pkg::OPD_W-1:0]     acc_reg, acc_next;
    logic [E_W-1:0]                e_reg, e_next;

    logic                          mul_start;
    logic [meu_pkg::OPD_W-1:0]     mul_x;
    logic [meu_pkg::OPD_W-1:0]     mul_y;
    logic                          mul_done;
    logic [meu_pkg::OPD_W-1:0]     mul_r;

    logic                          cfg_write;
    logic                          kind_ok;
    logic [E_W-1:0]                inv_exp;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= meu_pkg::MODULUS_RESET;
        end
        else if (cfg_write && (paddr == meu_pkg::ADDR_MODULUS))
        begin
            modulus_reg <= pwdata[meu_pkg::OPD_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr == meu_pkg::ADDR_MODULUS)
        begin
            prdata = meu_pkg::DATA_W'(modulus_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // request decode
    assign kind_ok = (kind == meu_pkg::KIND_POW) || (kind == meu_pkg::KIND_INV)
                     || (kind == meu_pkg::KIND_DIV);
    assign inv_exp = (modulus_reg >= 31'd2) ? E_W'(modulus_reg - 31'd2) : '0;

    // shared modular multiplier
    meu_modmul u_modmul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .m     (modulus_reg),
        .done  (mul_done),
        .r     (mul_r)
    );

    // sequencer over the exponent bits
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        done_next  = 1'b0;
        value_next = value_reg;
        kind_next  = kind_reg;
        base_next  = base_reg;
        a_next     = a_reg;
        acc_next   = acc_reg;
        e_next     = e_reg;
        mul_start  = 1'b0;
        mul_x      = acc_reg;
        mul_y      = a_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if ((modulus_reg == '0) || !kind_ok)
                    begin
                        done_next  = 1'b1;
                        value_next = '0;
                    end
                    else
                    begin
                        kind_next  = kind;
                        base_next  = base;
                        a_next     = (kind == meu_pkg::KIND_DIV) ? divisor : base;
                        acc_next   = meu_pkg::OPD_W'(1);
                        e_next     = (kind == meu_pkg::KIND_POW) ? E_W'(exponent) : inv_exp;
                        state_next = S_BIT;
                    end
                end
            end
            S_BIT:
            begin
                if (e_reg == '0)
                begin
                    if (kind_reg == meu_pkg::KIND_DIV)
                    begin
                        // dividend times the inverse of the divisor
                        mul_start  = 1'b1;
                        mul_x      = base_reg;
                        mul_y      = acc_reg;
                        op_next    = OP_FIN;
                        state_next = S_WAIT;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        value_next = acc_reg;
                        state_next = S_IDLE;
                    end
                end
                else if (e_reg[0])
                begin
                    mul_start  = 1'b1;
                    mul_x      = acc_reg;
                    mul_y      = a_reg;
                    op_next    = OP_ACC;
                    state_next = S_WAIT;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_x      = a_reg;
                    mul_y      = a_reg;
                    op_next    = OP_SQR;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (mul_done)
                begin
                    case (op_reg)
                        OP_ACC:
                        begin
                            acc_next   = mul_r;
                            e_next     = {e_reg[E_W-1:1], 1'b0};
                            state_next = S_BIT;
                        end
                        OP_SQR:
                        begin
                            a_next     = mul_r;
                            e_next     = e_reg >> 1;
                            state_next = S_BIT;
                        end
                        OP_FIN:
                        begin
                            done_next  = 1'b1;
                            value_next = mul_r;
                            state_next = S_IDLE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_ACC;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            done_reg  <= done_next;
        end
    end

    // operand and result registers
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        kind_reg  <= kind_next;
        base_reg  <= base_next;
        a_reg     <= a_next;
        acc_reg   <= acc_next;
        e_reg     <= e_next;
    end

    assign busy  = (state_reg != S_IDLE);
    assign done  = done_reg;
    assign value = value_reg;

endmodule

`default_nettype wire

// ===== tb/modular_exponentiation_unit_checker.sv =====
// checker for the modular exponentiation unit: predicts every result and compares it
`timescale 1ns / 100ps

module modular_exponentiation_unit_checker
#(
    parameter int EXP_W = meu_pkg::EXP_BITS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [meu_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [meu_pkg::DATA_W-1:0]  pwdata,
    input  wire logic [meu_pkg::DATA_W-1:0]  prdata,
    input  wire logic                        pready,
    input  wire logic                        start,
    input  wire logic                        busy,
    input  wire logic [1:0]                  kind,
    input  wire logic [meu_pkg::OPD_W-1:0]   base,
    input  wire logic [EXP_W-1:0]            exponent,
    input  wire logic [meu_pkg::OPD_W-1:0]   divisor,
    input  wire logic                        done,
    input  wire logic [meu_pkg::OPD_W-1:0]   value,
    output int                               fail_count,
    output int                               open_count
);

    import meu_pkg::*;

    logic [OPD_W-1:0] modulus_copy = MODULUS_RESET;
    logic [OPD_W-1:0] expected_values [$];
    logic [OPD_W-1:0] oldest;
    int failures = 0;
    int open_items = 0;

    assign fail_count = failures;
    assign open_count = open_items;

    // right-to-left square and multiply, accumulator starts at one
    function automatic logic [63:0] modpow(input logic [63:0] b, input logic [63:0] e,
                                           input logic [63:0] m);
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] rest;
        acc = 64'd1;
        sq = b;
        rest = e;
        while (rest != 64'd0)
        begin
            if (rest[0])
                acc = (acc * sq) % m;
            sq = (sq * sq) % m;
            rest = rest >> 1;
        end
        return acc;
    endfunction

    // fermat inverse; moduli below two use a zero exponent
    function automatic logic [63:0] fermat_inverse(input logic [63:0] b, input logic [63:0] m);
        return modpow(b, (m >= 64'd2) ? m - 64'd2 : 64'd0, m);
    endfunction

    function automatic logic [OPD_W-1:0] predict_value(input logic [1:0] k,
                                                      input logic [OPD_W-1:0] b,
                                                      input logic [EXP_W-1:0] e,
                                                      input logic [OPD_W-1:0] d,
                                                      input logic [OPD_W-1:0] m);
        logic [63:0] mw;
        logic [63:0] r;
        mw = 64'(m);
        r = 64'd0;
        if (mw != 64'd0)
        begin
            case (k)
                KIND_POW: r = modpow(64'(b), 64'(e), mw);
                KIND_INV: r = fermat_inverse(64'(b), mw);
                KIND_DIV: r = ((64'(b) % mw) * fermat_inverse(64'(d), mw)) % mw;
                default:  r = 64'd0;
            endcase
        end
        return r[OPD_W-1:0];
    endfunction

    // count a failure, report only the first few
    task automatic count_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("%0t mismatch: %0s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_copy = MODULUS_RESET;
            expected_values.delete();
            open_items = 0;
        end
        else
        begin
            // result against the oldest open item
            if (done)
            begin
                if (expected_values.size() == 0)
                    count_failure($sformatf("value %0d with no item open", value));
                else
                begin
                    oldest = expected_values.pop_front();
                    if (value !== oldest)
                        count_failure($sformatf("value expected %0d, got %0d", oldest, value));
                end
            end

            // accepted item, predicted with the modulus in force now
            if (start && !busy)
                expected_values.push_back(predict_value(kind, base, exponent, divisor,
                                                        modulus_copy));

            // register port
            if (psel && penable && pready && paddr == ADDR_MODULUS)
            begin
                if (pwrite)
                    modulus_copy = pwdata[OPD_W-1:0];
                else if (prdata[OPD_W-1:0] !== modulus_copy)
                    count_failure($sformatf("modulus read expected %0d, got %0d",
                                            modulus_copy, prdata[OPD_W-1:0]));
            end

            open_items = expected_values.size();
        end
    end

endmodule

// ===== tb/tb_modular_exponentiation_unit_core.sv =====
// testbench top for the modular exponentiation unit: stimulus, register writes and verdict
`timescale 1ns / 100ps

module tb_modular_exponentiation_unit_core;

    import meu_pkg::*;

    localparam int EXP_W = EXP_BITS_DEF;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int ITEMS_PER_PHASE = 19;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic [OPD_W-1:0] OPD_MAX = '1;
    localparam logic [EXP_W-1:0] EXP_MAX = '1;
    localparam logic [EXP_W-1:0] EXP_TOP = {1'b1, {(EXP_W-1){1'b0}}};

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              start;
    logic              busy;
    logic [1:0]        kind;
    logic [OPD_W-1:0]  base;
    logic [EXP_W-1:0]  exponent;
    logic [OPD_W-1:0]  divisor;
    logic              done;
    logic [OPD_W-1:0]  value;

    int fail_count;
    int open_count;
    int cycle_count = 0;
    int gap_pct = 0;
    logic [OPD_W-1:0] cur_modulus = MODULUS_RESET;
    logic [OPD_W-1:0] phase_modulus [6];

    modular_exponentiation_unit_core #(.EXP_BITS(EXP_W)) uut
    (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .kind(kind), .base(base), .exponent(exponent), .divisor(divisor),
        .done(done), .value(value)
    );

    modular_exponentiation_unit_checker #(.EXP_W(EXP_W)) u_checker
    (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .kind(kind), .base(base), .exponent(exponent), .divisor(divisor),
        .done(done), .value(value),
        .fail_count(fail_count), .open_count(open_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // operand: zero, maximum, a multiple of the modulus, small, or anything
    function automatic logic [OPD_W-1:0] pick_operand(input logic [OPD_W-1:0] m);
        logic [63:0] mult;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return OPD_MAX;
            2:
            begin
                if (m == '0)
                    return OPD_W'($urandom);
                mult = 64'($urandom_range(1, 32'(OPD_MAX) / 32'(m))) * 64'(m);
                return mult[OPD_W-1:0];
            end
            3: return OPD_W'($urandom_range(1, 15));
            default: return OPD_W'($urandom);
        endcase
    endfunction

    // exponent: zero, all ones, or a random length with its top bit set
    function automatic logic [EXP_W-1:0] pick_exponent();
        logic [63:0] bits;
        int len;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return EXP_MAX;
            default:
            begin
                len = $urandom_range(1, EXP_W);
                bits = {$urandom, $urandom};
                bits = bits & ((64'd1 << len) - 64'd1);
                bits[len-1] = 1'b1;
                return bits[EXP_W-1:0];
            end
        endcase
    endfunction

    // one item; entered and left at a falling edge
    task automatic send_request(input logic [1:0] k, input logic [OPD_W-1:0] b,
                                input logic [EXP_W-1:0] e, input logic [OPD_W-1:0] d);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        kind <= k;
        base <= b;
        exponent <= e;
        divisor <= d;
        start <= 1'b1;
        while (busy)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_request();
        logic [1:0] k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: k = KIND_POW;
            4, 5, 6:    k = KIND_INV;
            7, 8:       k = KIND_DIV;
            default:    k = KIND_SPARE;
        endcase
        send_request(k, pick_operand(cur_modulus), pick_exponent(), pick_operand(cur_modulus));
    endtask

    // hold off until every open item has its result
    task automatic wait_idle();
        start <= 1'b0;
        while (open_count != 0 || busy)
            @(negedge clk);
    endtask

    // setup and access cycle on the register port
    task automatic apb_access(input logic wr, input logic [DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ADDR_MODULUS;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // write the modulus with a random spare top bit, then read it back
    task automatic write_modulus(input logic [OPD_W-1:0] m);
        wait_idle();
        apb_access(1'b1, {1'($urandom_range(0, 1)), m});
        apb_access(1'b0, '0);
        cur_modulus = m;
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        kind = KIND_POW;
        base = '0;
        exponent = '0;
        divisor = '0;
        phase_modulus[0] = MODULUS_RESET;
        phase_modulus[1] = OPD_MAX;
        phase_modulus[2] = 31'd3;
        phase_modulus[3] = 31'd65537;
        phase_modulus[4] = 31'd1;
        phase_modulus[5] = OPD_W'($urandom_range(4, 32'(OPD_MAX) - 1));
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // modulus after reset
        apb_access(1'b0, '0);
        gap_pct = 37;

        // directed: zero exponent, extremes, multiples of the modulus, spare kind
        send_request(KIND_POW, 31'd2, '0, '0);
        send_request(KIND_POW, '0, '0, '0);
        send_request(KIND_POW, '0, 63'd5, '0);
        send_request(KIND_POW, OPD_MAX, EXP_MAX, OPD_MAX);
        send_request(KIND_POW, 31'd12345, EXP_TOP, '0);
        send_request(KIND_INV, 31'd3, '0, '0);
        send_request(KIND_INV, '0, EXP_MAX, OPD_MAX);
        send_request(KIND_INV, MODULUS_RESET, '0, '0);
        send_request(KIND_INV, OPD_MAX, '0, '0);
        send_request(KIND_DIV, OPD_MAX, '0, OPD_MAX);
        send_request(KIND_DIV, 31'd10, '0, '0);
        send_request(KIND_DIV, '0, '0, 31'd5);
        send_request(KIND_SPARE, OPD_MAX, EXP_MAX, OPD_MAX);

        // modulus of one: zero exponent still gives one
        write_modulus(31'd1);
        send_request(KIND_POW, 31'd5, '0, '0);
        send_request(KIND_POW, 31'd5, 63'd3, '0);
        send_request(KIND_INV, 31'd5, '0, '0);
        send_request(KIND_DIV, 31'd7, '0, 31'd3);

        // modulus of two: inverse exponent is zero
        write_modulus(31'd2);
        send_request(KIND_INV, 31'd3, '0, '0);
        send_request(KIND_DIV, 31'd3, '0, 31'd1);
        send_request(KIND_POW, 31'd3, EXP_MAX, '0);

        // zero modulus returns zero for every kind
        write_modulus('0);
        send_request(KIND_POW, 31'd9, '0, '0);
        send_request(KIND_INV, 31'd9, '0, '0);
        send_request(KIND_DIV, 31'd9, '0, 31'd4);

        // largest modulus
        write_modulus(OPD_MAX);
        send_request(KIND_INV, OPD_MAX - 31'd1, '0, '0);
        send_request(KIND_DIV, OPD_MAX - 31'd1, '0, 31'd2);

        // random items, three gap regimes over six moduli
        for (int p = 0; p < 6; p++)
        begin
            gap_pct = (p < 2) ? 37 : (p < 4) ? 71 : 0;
            write_modulus(phase_modulus[p]);
            repeat (ITEMS_PER_PHASE)
                send_random_request();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
